### rtl/core/rofc_pkg.sv
// Package for the RO purifier flush controller: register indexes, reset values,
// stream widths and the state and configuration record types.
// No dependencies; imported by ro_purifier_flush_controller_unit.
`default_nettype none

package rofc_pkg;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// Configuration port widths.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_RISE_STEP    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_LIMIT        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LIMIT       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_POWER_ON_FLUSH_S = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_FLUSH_S     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_FLUSH_S    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_MIN      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_HOURS       = 3'd7;

	// Register reset values.
	localparam logic [9:0] LOW_RISE_STEP_RST    = 10'd50;
	localparam logic [9:0] LOW_LIMIT_RST        = 10'd1000;
	localparam logic [5:0] HIGH_LIMIT_RST       = 6'd50;
	localparam logic [7:0] POWER_ON_FLUSH_S_RST = 8'd30;
	localparam logic [7:0] IDLE_FLUSH_S_RST     = 8'd20;
	localparam logic [7:0] SHORT_FLUSH_S_RST    = 8'd10;
	localparam logic [7:0] TIMEOUT_MIN_RST      = 8'd120;
	localparam logic [2:0] IDLE_HOURS_RST       = 3'd4;

	// A work flush is requested after this many production minutes.
	localparam logic [4:0] WORK_FLUSH_MINUTES = 5'd10;

	typedef struct packed {
		logic [9:0] low_rise_step;
		logic [9:0] low_limit;
		logic [5:0] high_limit;
		logic [7:0] power_on_flush_s;
		logic [7:0] idle_flush_s;
		logic [7:0] short_flush_s;
		logic [7:0] timeout_min;
		logic [2:0] idle_hours;
	} cfg_t;

	typedef struct packed {
		logic [9:0] low_deb_cnt;
		logic [5:0] high_deb_cnt;
		logic       supply_ok;
		logic       tank_full;
		logic       shortage;
		logic       producing;
		logic       timeout;
		logic       flush_active;
		logic [7:0] flush_countdown;
		logic       power_on_pending;
		logic       idle_pending;
		logic       work_pending;
		logic       fill_pending;
		logic       fill_armed;
		logic       pump_request;
		logic       valve_request;
		logic       pump_latched;
		logic       valve_latched;
		logic [3:0] work_minutes;
		logic [7:0] run_minutes;
		logic [2:0] idle_hours;
	} state_t;

endpackage

`default_nettype wire

### rtl/core/ro_purifier_flush_controller_unit.sv
// Result items are registered: one becomes valid in the cycle after its input is accepted.
// Throughput: one item per cycle; the output register lets the next item in
// on the cycle its result is taken, so only a stalled full output register
// holds s_tready low.
// Reset (arst_n low, asynchronous): state and configuration registers return to their
// defaults, the controller starts with a power-on flush pending, and no result is held.
// Top level of the RO purifier flush controller; uses rofc_pkg.
`default_nettype none

module ro_purifier_flush_controller_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port.
	input  wire logic                             cfg_wr_en,
	input  wire logic [rofc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [rofc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// Input stream. tdata from bit 0: tick_10ms, tick_100ms, tick_second,
	// tick_minute, tick_hour, low_switch_raw, high_switch_raw, leak_detected,
	// power_on, then zero fill.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [rofc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Output stream. tdata from bit 0: pump_drive, flush_valve_drive,
	// water_shortage, production_timeout, producing, flushing,
	// flush_seconds_left[7:0], then zero fill.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [rofc_pkg::OUT_TDATA_W-1:0]      m_tdata
);

	import rofc_pkg::*;

	cfg_t   cfg_q;
	state_t st_q;
	state_t st_d;

	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic                   in_accept;

	// Unpacked input fields.
	logic t10, t100, tsec, tmin, thour;
	logic low_raw, high_raw, leak, power;

	// Wide intermediate sums for the clamped and wrapping counters.
	logic [10:0] low_sum;
	logic [6:0]  high_sum;
	logic [4:0]  work_sum;
	logic [8:0]  run_sum;
	logic [3:0]  idle_sum;

	assign t10      = s_tdata[0];
	assign t100     = s_tdata[1];
	assign tsec     = s_tdata[2];
	assign tmin     = s_tdata[3];
	assign thour    = s_tdata[4];
	assign low_raw  = s_tdata[5];
	assign high_raw = s_tdata[6];
	assign leak     = s_tdata[7];
	assign power    = s_tdata[8];

	// The output register frees up when its item is taken.
	assign s_tready  = !m_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_rise_step    <= LOW_RISE_STEP_RST;
			cfg_q.low_limit        <= LOW_LIMIT_RST;
			cfg_q.high_limit       <= HIGH_LIMIT_RST;
			cfg_q.power_on_flush_s <= POWER_ON_FLUSH_S_RST;
			cfg_q.idle_flush_s     <= IDLE_FLUSH_S_RST;
			cfg_q.short_flush_s    <= SHORT_FLUSH_S_RST;
			cfg_q.timeout_min      <= TIMEOUT_MIN_RST;
			cfg_q.idle_hours       <= IDLE_HOURS_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOW_RISE_STEP:    cfg_q.low_rise_step    <= cfg_wdata[9:0];
				REG_LOW_LIMIT:        cfg_q.low_limit        <= cfg_wdata[9:0];
				REG_HIGH_LIMIT:       cfg_q.high_limit       <= cfg_wdata[5:0];
				REG_POWER_ON_FLUSH_S: cfg_q.power_on_flush_s <= cfg_wdata[7:0];
				REG_IDLE_FLUSH_S:     cfg_q.idle_flush_s     <= cfg_wdata[7:0];
				REG_SHORT_FLUSH_S:    cfg_q.short_flush_s    <= cfg_wdata[7:0];
				REG_TIMEOUT_MIN:      cfg_q.timeout_min      <= cfg_wdata[7:0];
				REG_IDLE_HOURS:       cfg_q.idle_hours       <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Next state for one tick; the sub-steps follow one another in order.
	always_comb begin
		st_d     = st_q;
		low_sum  = '0;
		high_sum = '0;
		work_sum = '0;
		run_sum  = '0;
		idle_sum = '0;

		// 10 ms: debounce the pressure switches.
		if (t10) begin
			if (!low_raw) begin
				low_sum = {1'b0, st_d.low_deb_cnt} + {1'b0, cfg_q.low_rise_step};
				if (low_sum >= {1'b0, cfg_q.low_limit}) begin
					low_sum        = {1'b0, cfg_q.low_limit};
					st_d.supply_ok = 1'b1;
				end
				st_d.low_deb_cnt = low_sum[9:0];
			end else if (st_d.low_deb_cnt <= 10'd2) begin
				st_d.low_deb_cnt = 10'd1;
				st_d.supply_ok   = 1'b0;
			end else begin
				st_d.low_deb_cnt = st_d.low_deb_cnt - 10'd1;
			end

			if (!high_raw) begin
				high_sum = {1'b0, st_d.high_deb_cnt} + 7'd1;
				if (high_sum >= {1'b0, cfg_q.high_limit}) begin
					high_sum       = {1'b0, cfg_q.high_limit};
					st_d.tank_full = 1'b0;
				end
				st_d.high_deb_cnt = high_sum[5:0];
			end else if (st_d.high_deb_cnt <= 6'd2) begin
				st_d.high_deb_cnt = 6'd1;
				st_d.tank_full    = 1'b1;
			end else begin
				st_d.high_deb_cnt = st_d.high_deb_cnt - 6'd1;
			end

			// 10 ms: pump and valve requests.
			if (st_d.timeout || st_d.shortage || leak || !power) begin
				st_d.pump_request  = 1'b0;
				st_d.valve_request = 1'b0;
			end else if (st_d.flush_active) begin
				if (st_d.flush_countdown != 8'd0) begin
					st_d.pump_request  = 1'b1;
					st_d.valve_request = 1'b1;
				end else begin
					st_d.flush_active  = 1'b0;
					st_d.pump_request  = 1'b0;
					st_d.valve_request = 1'b0;
				end
			end else begin
				st_d.pump_request  = st_d.producing;
				st_d.valve_request = 1'b0;
			end
		end

		if (t100) begin
			// 100 ms: latch the drives.
			st_d.pump_latched  = st_d.pump_request;
			st_d.valve_latched = st_d.valve_request;

			// 100 ms: start the highest-priority pending flush.
			if (st_d.power_on_pending) begin
				st_d.flush_countdown  = cfg_q.power_on_flush_s;
				st_d.flush_active     = 1'b1;
				st_d.power_on_pending = 1'b0;
			end else if (st_d.idle_pending) begin
				st_d.flush_countdown = cfg_q.idle_flush_s;
				st_d.flush_active    = 1'b1;
				st_d.idle_pending    = 1'b0;
			end else if (st_d.work_pending && st_d.producing) begin
				st_d.flush_countdown = cfg_q.short_flush_s;
				st_d.flush_active    = 1'b1;
				st_d.work_pending    = 1'b0;
			end else if (st_d.fill_pending) begin
				st_d.flush_countdown = cfg_q.short_flush_s;
				st_d.flush_active    = 1'b1;
				st_d.fill_pending    = 1'b0;
			end

			// 100 ms: shortage, production and tank-filled edge. During a
			// shortage the production flag keeps its value.
			if (!st_d.supply_ok) begin
				st_d.shortage = 1'b1;
			end else begin
				st_d.shortage = 1'b0;
				if (!st_d.tank_full) begin
					st_d.producing  = 1'b1;
					st_d.fill_armed = 1'b1;
				end else begin
					st_d.producing = 1'b0;
					if (st_d.fill_armed) begin
						st_d.fill_armed   = 1'b0;
						st_d.fill_pending = 1'b1;
					end
				end
			end
		end

		// 1 s: flush countdown stops at zero.
		if (tsec && st_d.flush_countdown != 8'd0) begin
			st_d.flush_countdown = st_d.flush_countdown - 8'd1;
		end

		// 1 min: production minute counters.
		if (tmin) begin
			if (st_d.producing) begin
				work_sum = {1'b0, st_d.work_minutes} + 5'd1;
				if (work_sum >= WORK_FLUSH_MINUTES) begin
					work_sum          = '0;
					st_d.work_pending = 1'b1;
				end
				st_d.work_minutes = work_sum[3:0];

				run_sum = {1'b0, st_d.run_minutes} + 9'd1;
				if (run_sum >= {1'b0, cfg_q.timeout_min}) begin
					run_sum      = '0;
					st_d.timeout = 1'b1;
				end
				st_d.run_minutes = run_sum[7:0];
			end else begin
				st_d.run_minutes = 8'd0;
			end
		end

		// 1 h: idle hour counter.
		if (thour && !st_d.producing) begin
			idle_sum = {1'b0, st_d.idle_hours} + 4'd1;
			if (idle_sum >= {1'b0, cfg_q.idle_hours}) begin
				idle_sum          = '0;
				st_d.idle_pending = 1'b1;
			end
			st_d.idle_hours = idle_sum[2:0];
		end
	end

	// Controller state, updated once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.low_deb_cnt      <= LOW_LIMIT_RST;
			st_q.high_deb_cnt     <= '0;
			st_q.supply_ok        <= 1'b1;
			st_q.tank_full        <= 1'b0;
			st_q.shortage         <= 1'b0;
			st_q.producing        <= 1'b0;
			st_q.timeout          <= 1'b0;
			st_q.flush_active     <= 1'b1;
			st_q.flush_countdown  <= '0;
			st_q.power_on_pending <= 1'b1;
			st_q.idle_pending     <= 1'b0;
			st_q.work_pending     <= 1'b0;
			st_q.fill_pending     <= 1'b0;
			st_q.fill_armed       <= 1'b1;
			st_q.pump_request     <= 1'b0;
			st_q.valve_request    <= 1'b0;
			st_q.pump_latched     <= 1'b0;
			st_q.valve_latched    <= 1'b0;
			st_q.work_minutes     <= '0;
			st_q.run_minutes      <= '0;
			st_q.idle_hours       <= '0;
		end else if (in_accept) begin
			st_q <= st_d;
		end
	end

	// Output register: valid flag under reset, payload loaded on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			m_data_q <= {2'b00, st_d.flush_countdown, st_d.flush_active,
				st_d.producing, st_d.timeout, st_d.shortage,
				st_d.valve_latched, st_d.pump_latched};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// A stalled full output register must hold off new items.
	a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !in_accept)
		else $error("item accepted while the result register is stalled");

	// The production timeout stays set until reset.
	a_timeout_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.timeout |=> st_q.timeout)
		else $error("production timeout cleared without reset");

	// The flush valve never opens without the pump running.
	a_valve_needs_pump: assert property (@(posedge clk) disable iff (!arst_n)
		(!st_q.valve_latched || st_q.pump_latched)
		&& (!st_q.valve_request || st_q.pump_request))
		else $error("valve drive set without pump drive");

endmodule

`default_nettype wire
